[sv/cbs_pkg.sv]
// Shared types and constants for the column boxcar smoother.
// Holds the item structs and the controller/datapath command and status
// structs. Depends on nothing.
`default_nettype none

package cbs_pkg;

    // Field widths fixed by the item format
    localparam int SAMPLE_W = 32;
    localparam int CFG_W    = 4;

    // Half-width in force after reset
    localparam logic [CFG_W-1:0] HALF_WINDOW_RESET = 4'd5;

    // Quotient bits resolved per divider cycle
    localparam int DIV_RADIX_BITS = 4;

    // One input item
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_in_column;
    } cbs_in_t;

    // One result item
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] smoothed;
        logic                       last;
    } cbs_out_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic setup;
        logic sum_step;
        logic div_init;
        logic div_step;
        logic push;
    } cbs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pending;
        logic sum_last;
        logic div_last;
        logic out_free;
    } cbs_status_t;

endpackage

`default_nettype wire

[sv/cbs_ctrl.sv]
// Sequencing state machine for the column boxcar smoother.
// Issues datapath commands from datapath status; uses cbs_pkg.
`default_nettype none

module cbs_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output cbs_pkg::cbs_cmd_t        cmd,
    input  wire cbs_pkg::cbs_status_t st
);
    import cbs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SUM,
        ST_DIV_INIT,
        ST_DIV,
        ST_PUSH
    } state_t;

    state_t state_reg;
    logic   s_ready_reg;

    // Hold state and the registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready_reg) begin
                        state_reg   <= ST_SETUP;
                        s_ready_reg <= 1'b0;
                    end
                end
                ST_SETUP: begin
                    if (!st.pending) begin
                        state_reg   <= ST_IDLE;
                        s_ready_reg <= 1'b1;
                    end else begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    if (st.sum_last) begin
                        state_reg <= ST_DIV_INIT;
                    end
                end
                ST_DIV_INIT: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (st.div_last) begin
                        state_reg <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (st.out_free) begin
                        state_reg <= ST_SETUP;
                    end
                end
                default: begin
                    state_reg   <= ST_IDLE;
                    s_ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign s_ready = s_ready_reg;

    // Decode commands for the current state
    always_comb begin
        cmd          = '0;
        cmd.accept   = (state_reg == ST_IDLE) && s_valid && s_ready_reg;
        cmd.setup    = (state_reg == ST_SETUP) && st.pending;
        cmd.sum_step = (state_reg == ST_SUM);
        cmd.div_init = (state_reg == ST_DIV_INIT);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.push     = (state_reg == ST_PUSH) && st.out_free;
    end

endmodule

`default_nettype wire

[sv/cbs_datapath.sv]
// Datapath of the column boxcar smoother: sample line, position tracking,
// window accumulator, radix-16 divider and result register. Uses cbs_pkg.
`default_nettype none

module cbs_datapath #(
    parameter int MAX_HALF   = 8,
    parameter int MAX_COLUMN = 65535
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire cbs_pkg::cbs_cmd_t          cmd,
    output cbs_pkg::cbs_status_t            st,
    input  wire cbs_pkg::cbs_in_t           s_data,
    input  wire logic                       cfg_valid,
    input  wire logic [cbs_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                       m_ready,
    output logic                            m_valid,
    output cbs_pkg::cbs_out_t               m_data
);
    import cbs_pkg::*;

    localparam int WIN_DEPTH = 2 * MAX_HALF + 1;
    localparam int AGE_W     = $clog2(WIN_DEPTH);
    localparam int HW_W      = $clog2(MAX_HALF + 1);
    localparam int POS_W     = $clog2(MAX_COLUMN + 1);
    localparam int SUM_W     = SAMPLE_W + AGE_W;
    localparam int MAG_W     = SUM_W - 1;
    localparam int D_W       = HW_W + 1;
    localparam int STEPS     = (MAG_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
    localparam int QW        = STEPS * DIV_RADIX_BITS;
    localparam int CNT_W     = $clog2(STEPS);

    // Configuration and column control
    logic [CFG_W-1:0]    half_window_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [HW_W-1:0]     hw_reg;
    logic                pending_reg;
    logic                m_valid_reg;

    // Item and window working registers
    logic [SAMPLE_W-1:0] tap_reg [WIN_DEPTH];
    logic [POS_W-1:0]    item_p_reg;
    logic                item_last_reg;
    logic [POS_W-1:0]    e_reg;
    logic [POS_W-1:0]    e_end_reg;
    logic [HW_W-1:0]     h_reg;
    logic [AGE_W-1:0]    k_reg;
    logic [AGE_W-1:0]    k_stop_reg;
    logic [SUM_W-1:0]    acc_reg;
    logic                neg_reg;
    logic [QW-1:0]       div_reg;
    logic [D_W-1:0]      rem_reg;
    logic [CNT_W-1:0]    cnt_reg;
    cbs_out_t            m_data_reg;

    // Accept-time values
    logic [HW_W-1:0]     hw_sat;
    logic [HW_W-1:0]     hw_cur;
    logic [POS_W-1:0]    hw_pos;
    logic                is_last;
    logic [POS_W-1:0]    first_e;

    // Setup-time values
    logic [POS_W-1:0]    c_pos;
    logic [POS_W-1:0]    h_pos;
    logic [HW_W-1:0]     h_cur;
    logic [AGE_W-1:0]    c_age;

    // Arithmetic
    logic [SAMPLE_W-1:0] tap_sel;
    logic [SUM_W-1:0]    acc_abs;
    logic [MAG_W-1:0]    mag_rnd;
    logic [D_W:0]        d_ext;
    logic [D_W-1:0]      rem_next;
    logic [QW-1:0]       div_next;
    logic [SAMPLE_W-1:0] quot;

    // Saturate the half-width and pick the one in force for this column
    always_comb begin
        hw_sat  = (32'(half_window_reg) > MAX_HALF) ? HW_W'(MAX_HALF)
                                                    : HW_W'(half_window_reg);
        hw_cur  = (pos_reg == '0) ? hw_sat : hw_reg;
        hw_pos  = POS_W'(hw_cur);
        is_last = s_data.last_in_column || (pos_reg >= POS_W'(MAX_COLUMN - 1));
        first_e = (pos_reg > hw_pos) ? (pos_reg - hw_pos) : '0;
    end

    // Window centre and clamped half-width for the position being emitted
    always_comb begin
        c_pos = item_p_reg - e_reg;
        h_pos = (e_reg < c_pos) ? e_reg : c_pos;
        if (POS_W'(hw_reg) < h_pos) begin
            h_pos = POS_W'(hw_reg);
        end
        h_cur = HW_W'(h_pos);
        c_age = AGE_W'(c_pos);
    end

    // One radix-16 step of the restoring divider
    always_comb begin
        logic [D_W:0]  r;
        logic [QW-1:0] dv;
        d_ext = {1'b0, h_reg, 1'b1};
        r     = {1'b0, rem_reg};
        dv    = div_reg;
        for (int i = 0; i < DIV_RADIX_BITS; i++) begin
            r  = {r[D_W-1:0], dv[QW-1]};
            dv = {dv[QW-2:0], 1'b0};
            if (r >= d_ext) begin
                r     = r - d_ext;
                dv[0] = 1'b1;
            end
        end
        rem_next = r[D_W-1:0];
        div_next = dv;
    end

    // Magnitude plus half the divisor gives round-to-nearest
    always_comb begin
        tap_sel = tap_reg[k_reg];
        acc_abs = acc_reg[SUM_W-1] ? (~acc_reg + SUM_W'(1)) : acc_reg;
        mag_rnd = acc_abs[MAG_W-1:0] + MAG_W'(h_reg);
        quot    = div_reg[SAMPLE_W-1:0];
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_window_reg <= HALF_WINDOW_RESET;
            pos_reg         <= '0;
            hw_reg          <= '0;
            pending_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                half_window_reg <= cfg_data;
            end
            if (cmd.accept) begin
                hw_reg <= hw_cur;
                if (is_last) begin
                    pos_reg     <= '0;
                    pending_reg <= 1'b1;
                end else begin
                    pos_reg     <= pos_reg + POS_W'(1);
                    pending_reg <= (pos_reg >= hw_pos);
                end
            end else if (cmd.push) begin
                pending_reg <= (e_reg != e_end_reg);
            end
            if (cmd.push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and working registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            tap_reg[0] <= s_data.sample;
            for (int i = 1; i < WIN_DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
            item_p_reg    <= pos_reg;
            item_last_reg <= is_last;
            if (is_last) begin
                e_reg     <= first_e;
                e_end_reg <= pos_reg;
            end else begin
                e_reg     <= pos_reg - hw_pos;
                e_end_reg <= pos_reg - hw_pos;
            end
        end
        if (cmd.setup) begin
            h_reg      <= h_cur;
            k_reg      <= c_age - AGE_W'(h_cur);
            k_stop_reg <= c_age + AGE_W'(h_cur);
            acc_reg    <= '0;
        end
        if (cmd.sum_step) begin
            acc_reg <= acc_reg + {{AGE_W{tap_sel[SAMPLE_W-1]}}, tap_sel};
            k_reg   <= k_reg + AGE_W'(1);
        end
        if (cmd.div_init) begin
            neg_reg <= acc_reg[SUM_W-1];
            div_reg <= QW'(mag_rnd);
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            div_reg <= div_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (cmd.push) begin
            m_data_reg.smoothed <= neg_reg ? (~quot + SAMPLE_W'(1)) : quot;
            m_data_reg.last     <= item_last_reg && (e_reg == item_p_reg);
            e_reg               <= e_reg + POS_W'(1);
        end
    end

    // Status back to the controller
    always_comb begin
        st.pending  = pending_reg;
        st.sum_last = (k_reg == k_stop_reg);
        st.div_last = (cnt_reg == CNT_W'(STEPS - 1));
        st.out_free = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

[sv/column_boxcar_smoother.sv]
// Top level of the column boxcar smoother: controller plus datapath.
// Depends on cbs_pkg, cbs_ctrl and cbs_datapath.
//
// Smooths one column of signed Q16.16 samples with a centred boxcar whose
// half-width shrinks towards both column ends (never beyond half_window,
// saturated to MAX_HALF and latched on a column's first sample). Results lag
// the input by the half-width; the sample flagged last (or the one at
// position MAX_COLUMN-1) flushes the rest of the column, up to MAX_HALF+1
// results. Items are handled one at a time. An item that yields no result
// frees the input again after the setup state. Each result passes through
// setup, the accumulator (one sample per cycle through the window line), a
// step forming the rounded magnitude, the divider (36-bit magnitude, 4
// quotient bits per cycle) and the output register load, which waits for
// the sink; the register holds a result while the next is computed. The
// user writes half_window through the cfg port only while the block is
// idle; the block itself does not enforce this. cfg_ready is always high.
`default_nettype none

module column_boxcar_smoother #(
    parameter int MAX_HALF   = 8,
    parameter int MAX_COLUMN = 65535
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire cbs_pkg::cbs_in_t           s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output cbs_pkg::cbs_out_t               m_data,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [cbs_pkg::CFG_W-1:0]  cfg_data
);
    import cbs_pkg::*;

    cbs_cmd_t    cmd;
    cbs_status_t st;

    assign cfg_ready = 1'b1;

    cbs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .st      (st)
    );

    cbs_datapath #(
        .MAX_HALF   (MAX_HALF),
        .MAX_COLUMN (MAX_COLUMN)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .s_data    (s_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

    // A new item only enters once every result of the previous one is out
    a_accept_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !st.pending)
        else $error("item accepted while results still pending");

    // Ready drops for at least the cycle after an accepted item
    a_ready_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready held high after accepting an item");

    // The divider starts only straight after the accumulator finishes
    a_sum_before_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_init |-> $past(cmd.sum_step && st.sum_last))
        else $error("divider started without a completed window sum");

    // A result is never loaded over one the sink has not taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !cmd.push)
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

[tb/column_boxcar_smoother_test.sv]
// Self-checking testbench for column_boxcar_smoother: drives columns of Q16.16 samples,
// predicts each centred mean by model or directed table and checks each result item.
// Depends on cbs_pkg and the column_boxcar_smoother RTL only.
`timescale 1ns / 100ps

module column_boxcar_smoother_test;
    import cbs_pkg::*;

    localparam int MAX_HALF       = 8;
    localparam int MAX_COLUMN     = 65535;
    localparam int LINE_DEPTH     = 2 * MAX_HALF + 1;
    localparam int MAX_RESULTS    = MAX_HALF + 1;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 57;
    localparam int PROBE_COUNT    = 24;

    // Receiver stall patterns
    typedef enum logic [1:0] {RX_FLOW, RX_COIN, RX_SPARSE, RX_BLOCKED} rx_mode_t;

    // One row of the directed table; want_* only used when typed is set
    typedef struct packed {
        bit                   write_half;
        logic [CFG_W-1:0]     new_half;
        logic [SAMPLE_W-1:0]  sample;
        bit                   flag;
        bit                   typed;
        logic [SAMPLE_W-1:0]  want_mean;
        bit                   want_last;
    } probe_row_t;

    // Expectation override travelling with a directed item
    typedef struct packed {
        bit       typed;
        cbs_out_t want;
    } row_note_t;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    cbs_in_t          s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    cbs_out_t         m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data  = '0;

    // Model state: sample line (newest first), column position and half-widths
    logic [SAMPLE_W-1:0] line_q [LINE_DEPTH] = '{default: '0};
    int unsigned         next_pos    = 0;
    int unsigned         emitted_pos = 0;
    int unsigned         column_half = 0;
    logic [CFG_W-1:0]    half_reg    = HALF_WINDOW_RESET;
    cbs_out_t            step_means [MAX_RESULTS];

    cbs_out_t  expected_means [$];
    row_note_t row_notes [$];

    int  failures      = 0;
    int  means_checked = 0;
    int  samples_in    = 0;
    int  columns_done  = 0;
    int  half_writes   = 0;
    int  idle_cycles   = 0;
    int  burst_left    = 0;
    bit  full_speed    = 1'b0;
    int  fresh_count;
    row_note_t note;
    cbs_out_t  want;

    rx_mode_t rx_mode   = RX_FLOW;
    int       rx_window = 0;
    int       rx_hold   = 0;

    probe_row_t probes [PROBE_COUNT] = '{
        // single-sample columns at the extremes, reset half-width
        '{1'b0, 4'd0,  32'h7FFFFFFF, 1'b1, 1'b1, 32'h7FFFFFFF, 1'b1},
        '{1'b0, 4'd0,  32'h80000000, 1'b1, 1'b1, 32'h80000000, 1'b1},
        // short column under the reset half-width
        '{1'b0, 4'd0,  32'hFFFFFFFF, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, 4'd0,  32'h00000002, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, 4'd0,  32'h00000003, 1'b1, 1'b0, 32'h0, 1'b0},
        // zero half-width passes samples straight through
        '{1'b1, 4'd0,  32'h12345678, 1'b0, 1'b1, 32'h12345678, 1'b0},
        '{1'b0, 4'd0,  32'hFEDCBA98, 1'b1, 1'b1, 32'hFEDCBA98, 1'b1},
        '{1'b0, 4'd0,  32'h00000000, 1'b1, 1'b1, 32'h00000000, 1'b1},
        // out-of-range half-width saturates; column shorter than the full window
        '{1'b1, 4'd15, 32'h7FFFFFFF, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, 4'd0,  32'h7FFFFFFF, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, 4'd0,  32'h7FFFFFFF, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, 4'd0,  32'h80000000, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, 4'd0,  32'h80000000, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, 4'd0,  32'h00018000, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, 4'd0,  32'hFFFF0000, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, 4'd0,  32'hFFFE8000, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, 4'd0,  32'h00000001, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, 4'd0,  32'h80000001, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, 4'd0,  32'h7FFFFFFE, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, 4'd0,  32'h00000000, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, 4'd0,  32'hFFFFFFFF, 1'b1, 1'b0, 32'h0, 1'b0},
        // negative rounding with half-width one
        '{1'b1, 4'd1,  32'hFFFFFFFF, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, 4'd0,  32'h00000000, 1'b0, 1'b0, 32'h0, 1'b0},
        '{1'b0, 4'd0,  32'hFFFFFFFF, 1'b1, 1'b0, 32'h0, 1'b0}
    };

    column_boxcar_smoother u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Rounded-to-nearest mean of the samples aged centre-h .. centre+h
    function automatic logic [SAMPLE_W-1:0] rounded_mean(input int unsigned centre,
                                                         input int unsigned h);
        longint            sum;
        longint unsigned   mag;
        longint unsigned   d;
        longint unsigned   q;
        int unsigned       k;
        int unsigned       age;
        sum = 0;
        for (k = 0; k <= 2 * h; k++) begin
            age = centre - h + k;
            if (age < LINE_DEPTH)
                sum += longint'($signed(line_q[age]));
        end
        d   = 2 * h + 1;
        mag = (sum < 0) ? -sum : sum;
        q   = (mag + d / 2) / d;
        if (sum < 0)
            q = -q;
        return q[SAMPLE_W-1:0];
    endfunction

    // Advance the column model by one sample; fill step_means, return the count
    function automatic int predict_means(input cbs_in_t item);
        int unsigned p;
        int unsigned hw;
        int unsigned e;
        int unsigned h;
        int          k;
        int          n;
        bit          closes;
        p = next_pos;
        n = 0;
        if (p == 0)
            column_half = (half_reg > MAX_HALF) ? MAX_HALF : half_reg;
        hw = column_half;
        for (k = LINE_DEPTH - 1; k > 0; k--)
            line_q[k] = line_q[k - 1];
        line_q[0] = item.sample;
        closes = item.last_in_column || (p >= MAX_COLUMN - 1);
        if (!closes) begin
            // emit the position that is now hw samples old
            if (p >= hw) begin
                e = p - hw;
                step_means[0] = '{smoothed: rounded_mean(p - e, (e < hw) ? e : hw),
                                  last: 1'b0};
                n = 1;
                emitted_pos = e + 1;
            end
            next_pos = p + 1;
        end else begin
            // flush the tail with windows clamped by both column ends
            for (e = emitted_pos; e <= p && n < MAX_RESULTS; e++) begin
                h = e;
                if (p - e < h)
                    h = p - e;
                if (hw < h)
                    h = hw;
                step_means[n] = '{smoothed: rounded_mean(p - e, h), last: (e == p)};
                n++;
            end
            next_pos    = 0;
            emitted_pos = 0;
            columns_done++;
        end
        return n;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'h7FFFFFFF - $urandom_range(0, 15);
            3, 4: return $urandom_range(0, 600) - 300;
            default: return $urandom();
        endcase
    endfunction

    function automatic int pick_length(input int half);
        case ($urandom_range(0, 9))
            0: return 1;
            1, 2: return $urandom_range(1, half + 1);
            3, 4, 5, 6: return $urandom_range(2, 2 * half + 3);
            default: return $urandom_range(2 * half + 1, 40);
        endcase
    endfunction

    // Offer one item, opening a random gap between bursts unless at full speed
    task automatic offer_sample(input logic [SAMPLE_W-1:0] value, input bit flag);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!full_speed) begin
                gap = $urandom_range(1, 12);
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= '{sample: value, last_in_column: flag};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Write the half-width once every expected item has drained
    task automatic set_half(input logic [CFG_W-1:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_means.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        burst_left = 0;
    endtask

    // Predict on accepted inputs, check accepted results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                half_reg = cfg_data;
                half_writes++;
            end
            if (s_valid && s_ready) begin
                fresh_count = predict_means(s_data);
                samples_in++;
                note = (row_notes.size() != 0) ? row_notes.pop_front() : '0;
                if (note.typed)
                    expected_means.push_back(note.want);
                else
                    for (int i = 0; i < fresh_count; i++)
                        expected_means.push_back(step_means[i]);
            end
            if (m_valid && m_ready) begin
                if (expected_means.size() == 0) begin
                    $error("unexpected item: smoothed %h last %b", m_data.smoothed, m_data.last);
                    failures++;
                end else begin
                    want = expected_means.pop_front();
                    if (m_data.smoothed !== want.smoothed) begin
                        $error("smoothed: expected %h, got %h", want.smoothed, m_data.smoothed);
                        failures++;
                    end
                    if (m_data.last !== want.last) begin
                        $error("last: expected %b, got %b", want.last, m_data.last);
                        failures++;
                    end
                    means_checked++;
                end
            end
        end
    end

    // Receiver: stall pattern changes at the end of each random-length window
    always @(posedge aclk) begin
        if (rx_window == 0) begin
            rx_mode   = rx_mode_t'($urandom_range(0, 3));
            rx_window = $urandom_range(16, 96);
        end else begin
            rx_window--;
        end
        if (full_speed || rx_mode == RX_FLOW) begin
            m_ready <= 1'b1;
        end else begin
            case (rx_mode)
                RX_COIN: m_ready <= $urandom_range(0, 1);
                RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default: begin
                    // hold off for a long run, then take one item
                    if (rx_hold == 0) begin
                        rx_hold = $urandom_range(5, 30);
                        m_ready <= 1'b1;
                    end else begin
                        rx_hold--;
                        m_ready <= 1'b0;
                    end
                end
            endcase
        end
    end

    // Watchdog: end the run if no channel moves an item for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("column_boxcar_smoother regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [CFG_W-1:0] phase_half [PHASES];
        int               budget;
        int               len;
        int               eff;
        phase_half = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd4, 4'd11, 4'd2, 4'd6};
        phase_half[5] = CFG_W'($urandom_range(9, 14));
        phase_half[7] = CFG_W'($urandom_range(0, 15));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        foreach (probes[i]) begin
            if (probes[i].write_half)
                set_half(probes[i].new_half);
            row_notes.push_back('{typed: probes[i].typed,
                                  want: '{smoothed: probes[i].want_mean,
                                          last: probes[i].want_last}});
            offer_sample(probes[i].sample, probes[i].flag);
        end

        // Random columns; after a mid-column stop the next write applies from the next column
        for (int phase = 0; phase < PHASES; phase++) begin
            set_half(phase_half[phase]);
            full_speed = (phase == 4);
            eff    = (phase_half[phase] > MAX_HALF) ? MAX_HALF : phase_half[phase];
            budget = PHASE_ITEMS;
            while (budget > 0) begin
                len = pick_length(eff);
                for (int j = 0; j < len && budget > 0; j++) begin
                    offer_sample(pick_sample(), j == len - 1);
                    budget--;
                end
            end
        end
        full_speed = 1'b0;

        // Drain outstanding results, then allow for a late stray item
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_means.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d samples in %0d columns with %0d half-width writes;",
                 samples_in, columns_done, half_writes);
        $display("%0d smoothed items checked across directed and random columns.",
                 means_checked);
        if (failures == 0)
            $display("column_boxcar_smoother regression: pass");
        else
            $display("column_boxcar_smoother regression: fail");
        $finish;
    end

endmodule

[filelist.f]
sv/cbs_pkg.sv
sv/cbs_ctrl.sv
sv/cbs_datapath.sv
sv/column_boxcar_smoother.sv
tb/column_boxcar_smoother_test.sv
